@@ rtl/core/tte_pkg.sv @@
// Package for the Taylor-series trig evaluator: item types, codes and series coefficients.
// Has no dependencies; used by the taylor_trig_evaluator top level.
`default_nettype none

package tte_pkg;

    localparam int ANG_W = 32;
    localparam int VAL_W = 56;

    localparam logic [1:0] CMD_SIN = 2'd0;
    localparam logic [1:0] CMD_COS = 2'd1;
    localparam logic [1:0] CMD_TAN = 2'd2;
    localparam logic [1:0] CMD_COT = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    localparam int NUM_TERMS = 5;

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [ANG_W-1:0] angle;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [1:0]              status;
    } result_t;

    // Numerators of the series coefficients, by function and term.
    localparam logic [5:0] COEF_NUM [0:3][0:NUM_TERMS-1] = '{
        '{6'd1, 6'd1, 6'd1, 6'd1,  6'd1},
        '{6'd1, 6'd1, 6'd1, 6'd1,  6'd1},
        '{6'd1, 6'd1, 6'd2, 6'd17, 6'd62},
        '{6'd1, 6'd1, 6'd1, 6'd2,  6'd1}
    };

    // Denominators scaled by 64, which takes a Q.30 power down to Q.24.
    localparam logic [24:0] COEF_DIV [0:3][0:NUM_TERMS-1] = '{
        '{25'd64, 25'd384, 25'd7680, 25'd322560, 25'd23224320},
        '{25'd64, 25'd128, 25'd1536, 25'd46080,  25'd2580480},
        '{25'd64, 25'd192, 25'd960,  25'd20160,  25'd181440},
        '{25'd64, 25'd192, 25'd2880, 25'd60480,  25'd302400}
    };

    localparam logic [58:0] P58 = 59'd1 << 58;

    // Reciprocals floor(2^64 / COEF_DIV), used for the division by a constant.
    localparam logic [58:0] COEF_RECIP [0:3][0:NUM_TERMS-1] = '{
        '{P58 / 59'd1, P58 / 59'd6, P58 / 59'd120, P58 / 59'd5040, P58 / 59'd362880},
        '{P58 / 59'd1, P58 / 59'd2, P58 / 59'd24,  P58 / 59'd720,  P58 / 59'd40320},
        '{P58 / 59'd1, P58 / 59'd3, P58 / 59'd15,  P58 / 59'd315,  P58 / 59'd2835},
        '{P58 / 59'd1, P58 / 59'd3, P58 / 59'd45,  P58 / 59'd945,  P58 / 59'd4725}
    };

    localparam logic COEF_NEG [0:3][0:NUM_TERMS-1] = '{
        '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
        '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1}
    };

endpackage

`default_nettype wire

@@ rtl/core/taylor_trig_evaluator.sv @@
// Taylor-series evaluator for sin, cos, tan and cot on a Q3.28 angle, Q31.24 result.
// Depends on tte_pkg for item types, codes and coefficient tables.
// Throughput: one item per cycle, except that the pipeline stalls while both output buffer entries are full.
// The 53-stage restoring divider for 1/x sets most of the latency.
// A two-entry output buffer lets the pipeline keep accepting while a result waits.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none

module taylor_trig_evaluator #(
    parameter int TERMS = 5
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire tte_pkg::item_t  item,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output tte_pkg::result_t     result
);
    import tte_pkg::*;

    localparam int DB  = 53;
    localparam int CW  = 58;
    localparam int P2W = 37;
    localparam int MW  = 58;
    localparam int SW  = 62;
    localparam int NCH = 8;
    localparam int S_PW  = DB + 1;
    localparam int S_T1  = S_PW + NCH + 1;
    localparam int S_SUM = S_T1 + 5;
    localparam int L     = S_SUM + 1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        xneg;
        logic [31:0] u;
        logic [31:0] rem;
        logic [DB-1:0] dvd;
        logic [DB-1:0] quo;
    } dv_t;

    typedef struct packed {
        logic [1:0]    cmd;
        logic          xneg;
        logic          czero;
        logic [DB-1:0] rq;
        logic [P2W-1:0] pw2;
        logic [NUM_TERMS-1:0][CW-1:0] c;
        logic [65:0]   plo;
        logic [65:0]   phi;
    } mn_t;

    typedef struct packed {
        logic [1:0]    cmd;
        logic          xneg;
        logic          czero;
        logic [DB-1:0] rq;
    } cm_t;

    logic adv;
    logic v_reg [0:L-1];

    dv_t dv_reg [0:DB];
    dv_t dv_next [0:DB];
    mn_t mn_reg [0:NCH];
    mn_t mn_next [0:NCH];
    cm_t cm_reg [1:5];
    cm_t cm_next [1:5];

    logic [63:0] n_reg [0:TERMS-1][1:4];
    logic [63:0] n1_next [0:TERMS-1];
    logic [63:0] p_reg [0:TERMS-1][0:3];
    logic [63:0] p_next [0:TERMS-1][0:3];
    logic [MW-1:0] q_reg [0:TERMS-1][3:4];
    logic [MW-1:0] q3_next [0:TERMS-1];
    logic [53:0] ql_reg [0:TERMS-1];
    logic [53:0] qh_reg [0:TERMS-1];
    logic [53:0] ql_next [0:TERMS-1];
    logic [53:0] qh_next [0:TERMS-1];
    logic [MW-1:0] mag_reg [0:TERMS-1];
    logic [MW-1:0] mag_next [0:TERMS-1];
    logic neg_reg [0:TERMS-1];
    logic neg_next [0:TERMS-1];

    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] sum_next;
    logic czero_reg;

    result_t res_item;
    result_t o_reg;
    result_t s_reg;
    logic ov_reg;
    logic sv_reg;
    logic pop;
    logic push;

    assign adv = !sv_reg;
    assign item_ready = adv;

    always_comb
    begin
        logic [31:0] raw;
        logic [32:0] t;
        logic ge;
        raw = item.angle;
        dv_next[0].cmd  = item.cmd;
        dv_next[0].xneg = raw[31];
        dv_next[0].u    = raw[31] ? (~raw + 32'd1) : raw;
        dv_next[0].rem  = '0;
        dv_next[0].dvd  = (DB'(1) << (DB - 1)) + DB'(dv_next[0].u >> 1);
        dv_next[0].quo  = '0;
        for (int j = 1; j <= DB; j++)
        begin
            t  = {dv_reg[j-1].rem, dv_reg[j-1].dvd[DB-1]};
            ge = t >= {1'b0, dv_reg[j-1].u};
            dv_next[j]     = dv_reg[j-1];
            dv_next[j].rem = ge ? 32'(t - {1'b0, dv_reg[j-1].u}) : t[31:0];
            dv_next[j].dvd = dv_reg[j-1].dvd << 1;
            dv_next[j].quo = {dv_reg[j-1].quo[DB-2:0], ge};
        end
    end

    always_comb
    begin
        logic [63:0] sq;
        logic [95:0] prod;
        dv_t src;
        src = dv_reg[DB];
        sq  = 64'(src.u) * 64'(src.u);
        mn_next[0]       = '0;
        mn_next[0].cmd   = src.cmd;
        mn_next[0].xneg  = src.xneg;
        mn_next[0].czero = (src.cmd == CMD_COT) && (src.u == 32'd0);
        mn_next[0].rq    = src.quo;
        mn_next[0].pw2   = P2W'((sq + (64'd1 << 25)) >> 26);
        mn_next[0].c[0]  = (src.cmd == CMD_COS) ? (CW'(1) << 30) : (CW'(src.u) << 2);
        for (int m = 1; m <= NCH; m++)
        begin
            mn_next[m] = mn_reg[m-1];
            prod = '0;
            if ((m % 2) == 1)
            begin
                mn_next[m].plo = 66'(mn_reg[m-1].c[3'((m-1)/2)][28:0]) * 66'(mn_reg[m-1].pw2);
                mn_next[m].phi = 66'(mn_reg[m-1].c[3'((m-1)/2)][57:29]) * 66'(mn_reg[m-1].pw2);
            end
            else
            begin
                prod = (96'(mn_reg[m-1].phi) << 29) + 96'(mn_reg[m-1].plo) + (96'd1 << 29);
                mn_next[m].c[3'(m/2)] = prod[87:30];
            end
        end
    end

    always_comb
    begin
        int idx;
        logic [58:0] rc;
        logic [127:0] acc;
        logic [24:0] d;
        logic [63:0] qd;
        logic [63:0] r;
        cm_next[1].cmd   = mn_reg[NCH].cmd;
        cm_next[1].xneg  = mn_reg[NCH].xneg;
        cm_next[1].czero = mn_reg[NCH].czero;
        cm_next[1].rq    = mn_reg[NCH].rq;
        for (int s = 2; s <= 5; s++)
        begin
            cm_next[s] = cm_reg[s-1];
        end
        for (int k = 0; k < TERMS; k++)
        begin
            idx = ((mn_reg[NCH].cmd == CMD_COT) && (k != 0)) ? k - 1 : k;
            n1_next[k] = 64'(mn_reg[NCH].c[3'(idx)]) * 64'(COEF_NUM[mn_reg[NCH].cmd][k])
                       + 64'(COEF_DIV[mn_reg[NCH].cmd][k] >> 1);

            rc = COEF_RECIP[cm_reg[1].cmd][k];
            p_next[k][0] = 64'(n_reg[k][1][31:0]) * 64'(rc[31:0]);
            p_next[k][1] = 64'(n_reg[k][1][31:0]) * 64'(rc[58:32]);
            p_next[k][2] = 64'(n_reg[k][1][63:32]) * 64'(rc[31:0]);
            p_next[k][3] = 64'(n_reg[k][1][63:32]) * 64'(rc[58:32]);

            acc = 128'(p_reg[k][0]) + (128'(p_reg[k][1]) << 32)
                + (128'(p_reg[k][2]) << 32) + (128'(p_reg[k][3]) << 64);
            q3_next[k] = acc[121:64];

            d = COEF_DIV[cm_reg[3].cmd][k];
            ql_next[k] = 54'(q_reg[k][3][28:0]) * 54'(d);
            qh_next[k] = 54'(q_reg[k][3][57:29]) * 54'(d);

            d  = COEF_DIV[cm_reg[4].cmd][k];
            qd = 64'(ql_reg[k]) + (64'(qh_reg[k]) << 29);
            r  = n_reg[k][4] - qd;
            if ((cm_reg[4].cmd == CMD_COT) && (k == 0))
            begin
                mag_next[k] = MW'(cm_reg[4].rq);
            end
            else
            begin
                mag_next[k] = (r >= 64'(d)) ? q_reg[k][4] + MW'(1) : q_reg[k][4];
            end
            neg_next[k] = COEF_NEG[cm_reg[4].cmd][k]
                        ^ ((cm_reg[4].cmd != CMD_COS) && cm_reg[4].xneg);
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] term;
        sum_next = '0;
        for (int k = 0; k < TERMS; k++)
        begin
            term = SW'(mag_reg[k]);
            sum_next = neg_reg[k] ? sum_next - term : sum_next + term;
        end
    end

    always_comb
    begin
        if (czero_reg)
        begin
            res_item.value  = VAL_MAX;
            res_item.status = ST_DIVZ;
        end
        else if (sum_reg > SW'(VAL_MAX))
        begin
            res_item.value  = VAL_MAX;
            res_item.status = ST_SAT;
        end
        else if (sum_reg < SW'(VAL_MIN))
        begin
            res_item.value  = VAL_MIN;
            res_item.status = ST_SAT;
        end
        else
        begin
            res_item.value  = sum_reg[VAL_W-1:0];
            res_item.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < L; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= item_valid;
            for (int i = 1; i < L; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j <= DB; j++)
            begin
                dv_reg[j] <= dv_next[j];
            end
            for (int m = 0; m <= NCH; m++)
            begin
                mn_reg[m] <= mn_next[m];
            end
            for (int s = 1; s <= 5; s++)
            begin
                cm_reg[s] <= cm_next[s];
            end
            for (int k = 0; k < TERMS; k++)
            begin
                n_reg[k][1] <= n1_next[k];
                n_reg[k][2] <= n_reg[k][1];
                n_reg[k][3] <= n_reg[k][2];
                n_reg[k][4] <= n_reg[k][3];
                for (int i = 0; i < 4; i++)
                begin
                    p_reg[k][i] <= p_next[k][i];
                end
                q_reg[k][3] <= q3_next[k];
                q_reg[k][4] <= q_reg[k][3];
                ql_reg[k]   <= ql_next[k];
                qh_reg[k]   <= qh_next[k];
                mag_reg[k]  <= mag_next[k];
                neg_reg[k]  <= neg_next[k];
            end
            sum_reg   <= sum_next;
            czero_reg <= cm_reg[5].czero;
        end
    end

    assign pop  = ov_reg && result_ready;
    assign push = adv && v_reg[L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (sv_reg)
        begin
            if (pop)
            begin
                sv_reg <= 1'b0;
            end
        end
        else if (push && ov_reg && !pop)
        begin
            sv_reg <= 1'b1;
        end
        else if (push)
        begin
            ov_reg <= 1'b1;
        end
        else if (pop)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sv_reg)
        begin
            if (pop)
            begin
                o_reg <= s_reg;
            end
        end
        else if (push && ov_reg && !pop)
        begin
            s_reg <= res_item;
        end
        else if (push)
        begin
            o_reg <= res_item;
        end
    end

    assign result_valid = ov_reg;
    assign result       = o_reg;

endmodule

`default_nettype wire

@@ test/taylor_trig_evaluator_test.sv @@
// Testbench for taylor_trig_evaluator: drives angle items through the valid/ready handshake
// and checks every result against a bit-exact fixed-point series predictor.
// Depends on tte_pkg and the taylor_trig_evaluator RTL.
`default_nettype none

module taylor_trig_evaluator_test;
    import tte_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;

    result_t expected_results[$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    localparam int CYCLE_LIMIT = 400000;

    taylor_trig_evaluator DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] mul_round_q30(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = a * b + (128'd1 << 29);
        return p[93:30];
    endfunction

    function automatic result_t series_value(item_t it);
        result_t r;
        logic [63:0] u;
        logic [63:0] pw[0:9];
        logic [127:0] mag;
        logic [127:0] d;
        logic signed [127:0] sum;
        logic xneg;
        logic odd;
        logic neg;
        int ex;
        int dens[4][5];
        int nums[4][5];
        int exps[4][5];
        bit negs[4][5];
        dens = '{'{1, 6, 120, 5040, 362880}, '{1, 2, 24, 720, 40320},
                 '{1, 3, 15, 315, 2835}, '{1, 3, 45, 945, 4725}};
        nums = '{'{1, 1, 1, 1, 1}, '{1, 1, 1, 1, 1}, '{1, 1, 2, 17, 62}, '{1, 1, 1, 2, 1}};
        exps = '{'{1, 3, 5, 7, 9}, '{0, 2, 4, 6, 8}, '{1, 3, 5, 7, 9}, '{-1, 1, 3, 5, 7}};
        negs = '{'{0, 1, 0, 1, 0}, '{0, 1, 0, 1, 0}, '{0, 0, 0, 0, 0}, '{0, 1, 1, 1, 1}};
        xneg = it.angle[31];
        u = xneg ? 64'(-{32'd0, it.angle}) & 64'hFFFFFFFF : 64'(it.angle) & 64'hFFFFFFFF;
        if (it.cmd == CMD_COT && u == 0)
        begin
            r.value = VAL_MAX;
            r.status = ST_DIVZ;
            return r;
        end
        pw[0] = 64'd1 << 30;
        pw[1] = u << 2;
        pw[2] = (u * u + (64'd1 << 25)) >> 26;
        for (int k = 3; k < 10; k++)
            pw[k] = mul_round_q30(pw[k - 2], pw[2]);
        sum = 0;
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            ex = exps[it.cmd][k];
            if (ex < 0)
            begin
                mag = ((128'd1 << 52) + (u >> 1)) / u;
                odd = 1'b1;
            end
            else
            begin
                d = 128'(dens[it.cmd][k]) << 6;
                mag = (128'(pw[ex]) * nums[it.cmd][k] + (d >> 1)) / d;
                odd = ex[0];
            end
            neg = negs[it.cmd][k] ^ (odd & xneg);
            sum = neg ? sum - $signed(mag) : sum + $signed(mag);
        end
        r.status = ST_OK;
        if (sum > $signed(128'(VAL_MAX)))
        begin
            sum = 128'(VAL_MAX);
            r.status = ST_SAT;
        end
        else if (sum < -(128'sd1 <<< 55))
        begin
            sum = -(128'sd1 <<< 55);
            r.status = ST_SAT;
        end
        r.value = sum[55:0];
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch in %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    task automatic send_angle(logic [1:0] cmd, logic [31:0] angle);
        item_t it;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        it.cmd = cmd;
        it.angle = angle;
        expected_results.push_back(series_value(it));
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (!item_ready);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
                report("unexpected result", result, 0);
            else
            begin
                if (result.value !== expected_results[0].value)
                    report("value", result.value, expected_results[0].value);
                if (result.status !== expected_results[0].status)
                    report("status", result.status, expected_results[0].status);
                void'(expected_results.pop_front());
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [31:0] random_angle();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(32'h3243F6A9)) * ($urandom_range(1) ? 1 : -1));
            2: return 32'($signed($urandom_range(255)) - 128);
            default: return $urandom_range(1) ? 32'h80000000 + $urandom_range(15)
                                              : 32'h7FFFFFFF - $urandom_range(15);
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] angles[11];
        angles = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                   32'h10000000, 32'hF0000000, 32'h3243F6A9, 32'h55555555,
                   32'hAAAAAAAA, 32'h08000000};
        foreach (angles[i])
            for (int c = 0; c < 4; c++)
                if (i < 6 || c == int'(CMD_COT) || c == int'(CMD_TAN))
                    send_angle(c[1:0], angles[i]);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_angle(2'($urandom_range(3)), random_angle());
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        test_random(150);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_idle_pct = 24;
        recv_idle_pct = 74;
        test_random(500);
        send_idle_pct = 74;
        recv_idle_pct = 24;
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(370);
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
